@@ rtl/qse_pkg.sv @@
// ----------------------------------------------------------------------------
// qse_pkg
// Shared constants and types for the quicksort engine.
// ----------------------------------------------------------------------------
package qse_pkg;

  localparam int unsigned QSE_DEPTH      = 64;
  localparam int unsigned QSE_DATA_WIDTH = 32;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PSTART,
    ST_PIVOT,
    ST_SCAN,
    ST_SWAP_RD,
    ST_SWAP_WR,
    ST_FIN_RD,
    ST_FIN_WR,
    ST_NEXT,
    ST_OUT_RD,
    ST_OUT_WAIT
  } qse_state_t;

endpackage

@@ rtl/quicksort_engine_top.sv @@
// ----------------------------------------------------------------------------
// quicksort_engine_top
// Loads a block of signed values and emits them sorted ascending.
// Load: one value per cycle. Sort: one compare per cycle of the Lomuto scan
// while no swap is under way; swaps and partition setup add states; about
// N*log2(N) compares on average, N*N/2 at worst; output via the single RAM port.
// Reset: sync active low; clears count, stack ptr, state, valid; RAM untouched.
// ----------------------------------------------------------------------------
module quicksort_engine_top #(
  parameter int unsigned DEPTH      = qse_pkg::QSE_DEPTH,
  parameter int unsigned DATA_WIDTH = qse_pkg::QSE_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_value,
  input  logic                         in_is_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_sorted_value,
  output logic                         out_last_out
);
  import qse_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned SD = AW + 1;
  localparam int unsigned SW = $clog2(SD + 1);

  qse_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [DATA_WIDTH-1:0] pivot_r, pivot_nxt, tmp_r, tmp_nxt;
  logic [AW-1:0] stk_lo_r [SD];
  logic [AW-1:0] stk_hi_r [SD];
  logic [SW-1:0] sp_r, sp_nxt;
  logic push;
  logic [AW-1:0] push_lo, push_hi;
  logic [CW-1:0] ocnt_r, ocnt_nxt;
  logic out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [DATA_WIDTH-1:0] out_data_r, out_data_nxt;

  logic          we;
  logic [AW-1:0] addr;
  logic [DATA_WIDTH-1:0] wdata, rdata;

  qse_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic [AW:0] left_len, right_len;
  logic lt;
  assign lt        = $signed(rdata) < $signed(pivot_r);
  assign left_len  = {1'b0, i_r} - {1'b0, lo_r};
  assign right_len = {1'b0, hi_r} - {1'b0, i_r};

  assign in_ready         = (state_r == ST_LOAD);
  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_data_r;
  assign out_last_out     = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r <= lo_nxt; hi_r <= hi_nxt; i_r <= i_nxt; j_r <= j_nxt;
    pivot_r <= pivot_nxt; tmp_r <= tmp_nxt; ocnt_r <= ocnt_nxt;
    out_data_r <= out_data_nxt; out_last_r <= out_last_nxt;
    if (push) begin
      stk_lo_r[sp_r[SW-1:0]] <= push_lo;
      stk_hi_r[sp_r[SW-1:0]] <= push_hi;
    end
  end

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; sp_nxt = sp_r;
    lo_nxt = lo_r; hi_nxt = hi_r; i_nxt = i_r; j_nxt = j_r;
    pivot_nxt = pivot_r; tmp_nxt = tmp_r; ocnt_nxt = ocnt_r;
    out_valid_nxt = out_valid_r; out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    we = 1'b0; addr = count_r[AW-1:0]; wdata = in_value;
    push = 1'b0; push_lo = '0; push_hi = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (count_r < CW'(DEPTH)) begin
            we = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          if (in_is_last) begin
            lo_nxt = '0;
            if (count_r < CW'(DEPTH)) hi_nxt = count_r[AW-1:0];
            else hi_nxt = AW'(DEPTH - 1);
            // a single element needs no sort
            if (count_r == '0) begin
              state_nxt = ST_OUT_RD;
            end else begin
              state_nxt = ST_PSTART;
            end
            ocnt_nxt = '0;
          end
        end
      end
      ST_PSTART: begin
        addr = hi_r;
        state_nxt = ST_PIVOT;
      end
      ST_PIVOT: begin
        pivot_nxt = rdata;
        i_nxt = lo_r; j_nxt = lo_r;
        addr = lo_r;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        // rdata = store[j]
        if (j_r == hi_r) begin
          addr = i_r;
          state_nxt = ST_FIN_RD;
        end else if (lt) begin
          tmp_nxt = rdata;
          addr = i_r;
          state_nxt = ST_SWAP_RD;
        end else begin
          j_nxt = j_r + 1'b1;
          addr = j_r + 1'b1;
        end
      end
      ST_SWAP_RD: begin
        // rdata = store[i]; write it to j
        we = 1'b1; addr = j_r; wdata = rdata;
        state_nxt = ST_SWAP_WR;
      end
      ST_SWAP_WR: begin
        we = 1'b1; addr = i_r; wdata = tmp_r;
        i_nxt = i_r + 1'b1;
        j_nxt = j_r + 1'b1;
        // port busy with the write; read the next j in the following cycle
        state_nxt = ST_FIN_WR;
      end
      ST_FIN_WR: begin
        addr = j_r;
        state_nxt = ST_SCAN;
      end
      ST_FIN_RD: begin
        // rdata = store[i]; swap with pivot at hi
        we = 1'b1; addr = hi_r; wdata = rdata;
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        we = 1'b1; addr = i_r; wdata = pivot_r;
        if (left_len >= 2 && right_len >= 2) begin
          push = (sp_r < SW'(SD));
          if (push) begin
            sp_nxt = sp_r + 1'b1;
            if (left_len > right_len) begin
              push_lo = lo_r; push_hi = i_r - 1'b1; lo_nxt = i_r + 1'b1;
            end else begin
              push_lo = i_r + 1'b1; push_hi = hi_r; hi_nxt = i_r - 1'b1;
            end
          end
          state_nxt = ST_PSTART;
        end else if (left_len >= 2) begin
          hi_nxt = i_r - 1'b1; state_nxt = ST_PSTART;
        end else if (right_len >= 2) begin
          lo_nxt = i_r + 1'b1; state_nxt = ST_PSTART;
        end else if (sp_r == '0) begin
          state_nxt = ST_OUT_RD;
        end else begin
          sp_nxt = sp_r - 1'b1;
          lo_nxt = stk_lo_r[sp_r - 1'b1];
          hi_nxt = stk_hi_r[sp_r - 1'b1];
          state_nxt = ST_PSTART;
        end
      end
      ST_OUT_RD: begin
        addr = ocnt_r[AW-1:0];
        if (ocnt_r == count_r) begin
          count_nxt = '0; sp_nxt = '0;
          state_nxt = ST_LOAD;
        end else if (!out_valid_r || out_ready) begin
          state_nxt = ST_OUT_WAIT;
        end
      end
      ST_OUT_WAIT: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = rdata;
        out_last_nxt  = (ocnt_r + 1'b1 == count_r);
        ocnt_nxt      = ocnt_r + 1'b1;
        state_nxt     = ST_OUT_RD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  a_ready_only_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_LOAD) else $error("ready outside load");
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SW'(SD)) else $error("stack overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sorted_value))
    else $error("output dropped");

endmodule

@@ rtl/qse_ram.sv @@
// ----------------------------------------------------------------------------
// qse_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module qse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ tb/quicksort_engine_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quicksort_engine_top_tb
// Sends blocks of signed values to the sorter and checks every emitted value
// and its end marker against a locally sorted copy of the block. Covers
// single-element blocks, full and overfull stores, duplicates and extremes,
// with random gaps and stalls on both channels and one long output stall.
// ----------------------------------------------------------------------------
module quicksort_engine_top_tb;
  import qse_pkg::*;

  localparam int DW = QSE_DATA_WIDTH;
  localparam int NSTORE = QSE_DEPTH;

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 is_last;
  } elem_t;

  typedef struct packed {
    logic signed [DW-1:0] sorted_value;
    logic                 last_out;
  } sorted_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DW-1:0] in_value = '0;
  logic in_is_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DW-1:0] out_sorted_value;
  logic out_last_out;

  quicksort_engine_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_value(in_value), .in_is_last(in_is_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_sorted_value(out_sorted_value), .out_last_out(out_last_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  elem_t   pending_q[$];
  sorted_t sorted_q[$];
  logic signed [DW-1:0] block_buf[$];
  int mismatches = 0;
  int n_blocks = 0;
  int n_sent = 0;
  int n_outs = 0;
  int hold_cycles = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit in_taken = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Store only what fits, sort ascending, queue one expectation per stored element.
  task automatic sort_into_expect(input elem_t it);
    logic signed [DW-1:0] t;
    if (block_buf.size() < NSTORE) block_buf.push_back(it.value);
    if (it.is_last) begin
      for (int i = 1; i < block_buf.size(); i++) begin
        t = block_buf[i];
        for (int j = i - 1; j >= -1; j--) begin
          if (j < 0 || block_buf[j] <= t) begin
            block_buf[j+1] = t;
            break;
          end
          block_buf[j+1] = block_buf[j];
        end
      end
      foreach (block_buf[k])
        sorted_q.push_back('{block_buf[k], k == block_buf.size() - 1});
      block_buf.delete();
    end
  endtask

  // input accept bookkeeping at the accepting edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sort_into_expect('{in_value, in_is_last});
      n_sent++;
      void'(pending_q.pop_front());
      in_gap = pick_gap();
      in_taken = 1'b1;
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        in_taken = 1'b0;
        if (in_gap > 0 || pending_q.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_value <= pending_q[0].value;
          in_is_last <= pending_q[0].is_last;
        end
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_outs++;
      if (sorted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output transaction: value %0d last %0b",
                   out_sorted_value, out_last_out);
      end else begin
        if (out_sorted_value !== sorted_q[0].sorted_value ||
            out_last_out !== sorted_q[0].last_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %0d last %0b, got %0d last %0b",
                     sorted_q[0].sorted_value, sorted_q[0].last_out,
                     out_sorted_value, out_last_out);
        end
        void'(sorted_q.pop_front());
      end
    end
  end

  task automatic add_block(input int n, input int mode);
    logic signed [DW-1:0] v;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: v = $urandom();
        1: v = $signed($urandom_range(0, 6)) - 3;
        2: v = (i % 2) ? {1'b0, {(DW-1){1'b1}}} : {1'b1, {(DW-1){1'b0}}};
        3: v = i;
        default: v = n - i;
      endcase
      pending_q.push_back('{v, i == n - 1});
    end
    n_blocks++;
  endtask

  initial begin
    int total;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    // directed
    pending_q.push_back('{{1'b1, {(DW-1){1'b0}}}, 1'b1});
    n_blocks++;
    pending_q.push_back('{'1, 1'b0});
    pending_q.push_back('{{1'b0, {(DW-1){1'b1}}}, 1'b1});
    n_blocks++;
    add_block(6, 2);
    add_block(8, 3);
    add_block(7, 4);
    // random: mostly small blocks, a few near full, full or overfull
    total = 0;
    while (total < 196) begin
      int n, m;
      m = $urandom_range(0, 4);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(NSTORE - 2, NSTORE + 4)
                                      : $urandom_range(1, 12);
      add_block(n, m);
      total += n;
    end
    wait (n_sent > 40);
    @(posedge clk) hold_cycles = 400;
    wait (pending_q.size() == 0);
    wait (sorted_q.size() == 0);
    repeat (3 * NSTORE * 8) @(posedge clk);
    $display("Sent %0d transactions in %0d blocks; checked %0d sorted outputs.",
             n_sent, n_blocks, n_outs);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout");
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ quicksort_engine_top.f @@
rtl/qse_pkg.sv
rtl/qse_ram.sv
rtl/quicksort_engine_top.sv
tb/quicksort_engine_top_tb.sv
